>>> hw/rtl/fwsd_pkg.sv
// shared constants, codes, types and the direction pin table of the four wheel drive
`timescale 1ns / 1ps

package fwsd_pkg;

  // defaults for the top level parameters
  localparam int US_PER_MS_DEF  = 1000;
  localparam int COUNT_BITS_DEF = 31;

  // fixed widths
  localparam int WHEELS      = 4;
  localparam int DUTY_W      = 8;
  localparam int TIME_W      = 32;
  localparam int OUT_COUNT_W = 31;
  localparam int DELAY_W     = 16;
  localparam int PINS_W      = 4;

  localparam logic [DELAY_W-1:0] SYNC_DELAY_RESET = 16'd500;
  localparam logic [DUTY_W-1:0]  DUTY_MAX         = 8'd255;

  // action codes
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_MOVE  = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_SYNC  = 3'd4;

  // direction codes; the two codes above these keep the pins
  localparam logic [2:0] DIR_FWD  = 3'd0;
  localparam logic [2:0] DIR_BACK = 3'd1;
  localparam logic [2:0] DIR_LEFT = 3'd2;
  localparam logic [2:0] DIR_RGHT = 3'd3;
  localparam logic [2:0] DIR_CW   = 3'd4;
  localparam logic [2:0] DIR_CCW  = 3'd5;

  // commands from the drive control to the wheel timer
  typedef struct packed {
    logic       advance;
    logic       tick;
    logic       clear;
    logic [3:0] edges;
    logic [1:0] sel;
  } timer_cmd_t;

  // pin pattern for a direction: backward pins high nibble, forward pins low nibble
  function automatic logic [2*PINS_W-1:0] pin_pattern(input logic [2:0] dir);
    logic [2*PINS_W-1:0] pat;
    unique case (dir)
      DIR_FWD:  pat = {4'h0, 4'hF};
      DIR_BACK: pat = {4'hF, 4'h0};
      DIR_LEFT: pat = {4'h9, 4'h6};
      DIR_RGHT: pat = {4'h6, 4'h9};
      DIR_CW:   pat = {4'hA, 4'h5};
      DIR_CCW:  pat = {4'h5, 4'hA};
      default:  pat = '0;
    endcase
    return pat;
  endfunction

endpackage

>>> hw/rtl/fwsd_wheel_timer.sv
// time base, encoder edge stamping and edge counts of the four wheels
`timescale 1ns / 1ps

module fwsd_wheel_timer #(
  parameter int US_PER_MS  = fwsd_pkg::US_PER_MS_DEF,
  parameter int COUNT_BITS = fwsd_pkg::COUNT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  fwsd_pkg::timer_cmd_t                          cmd,
  output logic [fwsd_pkg::TIME_W-1:0]                   milli_time,
  output logic [fwsd_pkg::WHEELS-1:0][fwsd_pkg::TIME_W-1:0] edge_period,
  output logic [fwsd_pkg::OUT_COUNT_W-1:0]              average_count,
  output logic [fwsd_pkg::OUT_COUNT_W-1:0]              wheel_count
);
  import fwsd_pkg::*;

  localparam int PRESCALE_W = $clog2(US_PER_MS + 1);
  localparam int SUM_W      = COUNT_BITS + 2;
  localparam int EXT_W      = COUNT_BITS + 33;

  logic [TIME_W-1:0]     micro_time, micro_time_next;
  logic [PRESCALE_W-1:0] milli_prescale, milli_prescale_next, prescale_inc;
  logic [TIME_W-1:0]     milli_time_q, milli_time_next;
  logic [TIME_W-1:0]     last_edge_time [WHEELS];
  logic [TIME_W-1:0]     last_edge_time_next [WHEELS];
  logic [TIME_W-1:0]     period [WHEELS];
  logic [TIME_W-1:0]     period_next [WHEELS];
  logic [COUNT_BITS-1:0] edge_total [WHEELS];
  logic [COUNT_BITS-1:0] edge_total_next [WHEELS];
  logic [SUM_W-1:0]      count_sum;
  logic [EXT_W-1:0]      avg_ext, sel_ext;

  // clocks advance first, then edges are stamped with the new microsecond time
  always_comb begin
    micro_time_next     = micro_time;
    milli_prescale_next = milli_prescale;
    milli_time_next     = milli_time_q;
    prescale_inc        = milli_prescale + PRESCALE_W'(1);
    for (int w = 0; w < WHEELS; w++) begin
      last_edge_time_next[w] = last_edge_time[w];
      period_next[w]         = period[w];
      edge_total_next[w]     = edge_total[w];
    end
    if (cmd.tick) begin
      micro_time_next = micro_time + TIME_W'(1);
      if (prescale_inc == PRESCALE_W'(US_PER_MS)) begin
        milli_prescale_next = '0;
        milli_time_next     = milli_time_q + TIME_W'(1);
      end else begin
        milli_prescale_next = prescale_inc;
      end
      for (int w = 0; w < WHEELS; w++) begin
        if (cmd.edges[w]) begin
          period_next[w]         = micro_time_next - last_edge_time[w];
          last_edge_time_next[w] = micro_time_next;
          if (edge_total[w] != {COUNT_BITS{1'b1}}) begin
            edge_total_next[w] = edge_total[w] + COUNT_BITS'(1);
          end
        end
      end
    end
    if (cmd.clear) begin
      for (int w = 0; w < WHEELS; w++) begin
        edge_total_next[w] = '0;
      end
    end
  end

  // counts as they stand after this word
  always_comb begin
    count_sum = SUM_W'(edge_total_next[0]) + SUM_W'(edge_total_next[1])
              + SUM_W'(edge_total_next[2]) + SUM_W'(edge_total_next[3]);
    avg_ext       = EXT_W'(count_sum >> 2);
    sel_ext       = EXT_W'(edge_total_next[cmd.sel]);
    average_count = avg_ext[OUT_COUNT_W-1:0];
    wheel_count   = sel_ext[OUT_COUNT_W-1:0];
  end

  // current periods and time for the sync compare
  always_comb begin
    milli_time = milli_time_q;
    for (int w = 0; w < WHEELS; w++) begin
      edge_period[w] = period[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      micro_time     <= '0;
      milli_prescale <= '0;
      milli_time_q   <= '0;
      for (int w = 0; w < WHEELS; w++) begin
        last_edge_time[w] <= '0;
        period[w]         <= '0;
        edge_total[w]     <= '0;
      end
    end else if (cmd.advance) begin
      micro_time     <= micro_time_next;
      milli_prescale <= milli_prescale_next;
      milli_time_q   <= milli_time_next;
      for (int w = 0; w < WHEELS; w++) begin
        last_edge_time[w] <= last_edge_time_next[w];
        period[w]         <= period_next[w];
        edge_total[w]     <= edge_total_next[w];
      end
    end
  end

endmodule

>>> hw/rtl/four_wheel_speed_sync_drive.sv
// top level of the four wheel drive: stream handshake, drive pins, duties and speed sync
`timescale 1ns / 1ps

// Four wheel drive with encoder timing. One word is taken every clock as long as the
// result side takes words, and each word gives one result word; a word passes an input
// register and then a result register, and the sustained rate is one word per cycle
// while the result side takes words. Each word's state update (time base, edge stamps
// and counts in the wheel timer, pins and duties here) is done combinationally between
// the two registers. The input word carries the action in s_tuser; the delay register
// for speed sync is written on the cfg channel, which is always ready.
module four_wheel_speed_sync_drive #(
  parameter int US_PER_MS  = fwsd_pkg::US_PER_MS_DEF,
  parameter int COUNT_BITS = fwsd_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // edges [3:0], direction [6:4], duty [14:7], wheel_select [16:15], zero fill above
  input  logic [23:0]                      s_tdata,
  // action [2:0]
  input  logic [2:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // forward_pins [3:0], backward_pins [7:4], pwm_front_left [15:8],
  // pwm_front_right [23:16], pwm_back_left [31:24], pwm_back_right [39:32],
  // average_count [70:40], wheel_count [101:71], zero fill above
  output logic [103:0]                     m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fwsd_pkg::DELAY_W-1:0]     cfg_data
);
  import fwsd_pkg::*;

  // input register
  logic              in_valid;
  logic [2:0]        in_action;
  logic [3:0]        in_edges;
  logic [2:0]        in_dir;
  logic [DUTY_W-1:0] in_duty;
  logic [1:0]        in_sel;
  logic              advance;

  // drive state
  logic [DELAY_W-1:0] sync_delay_ms;
  logic [TIME_W-1:0]  move_start_ms, move_start_ms_next;
  logic [PINS_W-1:0]  fwd_pin_state, fwd_pin_state_next;
  logic [PINS_W-1:0]  bwd_pin_state, bwd_pin_state_next;
  logic [DUTY_W-1:0]  duty_setting [WHEELS];
  logic [DUTY_W-1:0]  duty_setting_next [WHEELS];
  logic [DUTY_W-1:0]  duty_on_pin [WHEELS];
  logic [DUTY_W-1:0]  duty_on_pin_next [WHEELS];
  logic [2*PINS_W-1:0] pat;
  logic [TIME_W-1:0]  elapsed;
  logic               sync_ok;

  // timer link
  timer_cmd_t                        tcmd;
  logic [TIME_W-1:0]                 milli_time;
  logic [WHEELS-1:0][TIME_W-1:0]     edge_period;
  logic [OUT_COUNT_W-1:0]            average_next, wheel_next;

  // result register
  logic [PINS_W-1:0]      out_fwd, out_bwd;
  logic [DUTY_W-1:0]      out_pwm [WHEELS];
  logic [OUT_COUNT_W-1:0] out_avg, out_wheel;

  // handshake: the input register moves on whenever the result register is free or is being taken
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_edges  <= s_tdata[3:0];
      in_dir    <= s_tdata[6:4];
      in_duty   <= s_tdata[14:7];
      in_sel    <= s_tdata[16:15];
    end
  end

  // time base and edge counting
  always_comb begin
    tcmd.advance = advance;
    tcmd.tick    = (in_action == ACT_TICK);
    tcmd.clear   = (in_action == ACT_CLEAR);
    tcmd.edges   = in_edges;
    tcmd.sel     = in_sel;
  end

  fwsd_wheel_timer #(
    .US_PER_MS  (US_PER_MS),
    .COUNT_BITS (COUNT_BITS)
  ) u_timer (
    .clk           (clk),
    .rst           (rst),
    .cmd           (tcmd),
    .milli_time    (milli_time),
    .edge_period   (edge_period),
    .average_count (average_next),
    .wheel_count   (wheel_next)
  );

  // move, stop and speed sync
  always_comb begin
    pat                = pin_pattern(in_dir);
    elapsed            = milli_time - move_start_ms;
    sync_ok            = elapsed > TIME_W'(sync_delay_ms);
    move_start_ms_next = move_start_ms;
    fwd_pin_state_next = fwd_pin_state;
    bwd_pin_state_next = bwd_pin_state;
    for (int w = 0; w < WHEELS; w++) begin
      duty_setting_next[w] = duty_setting[w];
      duty_on_pin_next[w]  = duty_on_pin[w];
    end
    unique case (in_action)
      ACT_MOVE: begin
        if (in_dir < 3'd6) begin
          fwd_pin_state_next = pat[PINS_W-1:0];
          bwd_pin_state_next = pat[2*PINS_W-1:PINS_W];
        end
        for (int w = 0; w < WHEELS; w++) begin
          duty_setting_next[w] = in_duty;
          duty_on_pin_next[w]  = in_duty;
        end
        move_start_ms_next = milli_time;
      end
      ACT_STOP: begin
        fwd_pin_state_next = '0;
        bwd_pin_state_next = '0;
        for (int w = 0; w < WHEELS; w++) begin
          duty_on_pin_next[w] = '0;
        end
      end
      ACT_SYNC: begin
        if (sync_ok) begin
          // nudge the other three wheels toward the front left period
          for (int w = 1; w < WHEELS; w++) begin
            if (edge_period[w] > edge_period[0]) begin
              if (duty_setting[w] != DUTY_MAX) begin
                duty_setting_next[w] = duty_setting[w] + DUTY_W'(1);
              end
            end else if (edge_period[w] < edge_period[0]) begin
              if (duty_setting[w] != '0) begin
                duty_setting_next[w] = duty_setting[w] - DUTY_W'(1);
              end
            end
            duty_on_pin_next[w] = duty_setting_next[w];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // drive state and delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_delay_ms <= SYNC_DELAY_RESET;
      move_start_ms <= '0;
      fwd_pin_state <= '0;
      bwd_pin_state <= '0;
      for (int w = 0; w < WHEELS; w++) begin
        duty_setting[w] <= '0;
        duty_on_pin[w]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        sync_delay_ms <= cfg_data;
      end
      if (advance) begin
        move_start_ms <= move_start_ms_next;
        fwd_pin_state <= fwd_pin_state_next;
        bwd_pin_state <= bwd_pin_state_next;
        for (int w = 0; w < WHEELS; w++) begin
          duty_setting[w] <= duty_setting_next[w];
          duty_on_pin[w]  <= duty_on_pin_next[w];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fwd   <= fwd_pin_state_next;
      out_bwd   <= bwd_pin_state_next;
      out_avg   <= average_next;
      out_wheel <= wheel_next;
      for (int w = 0; w < WHEELS; w++) begin
        out_pwm[w] <= duty_on_pin_next[w];
      end
    end
  end

  assign m_tdata = {2'b00, out_wheel, out_avg, out_pwm[3], out_pwm[2], out_pwm[1],
                    out_pwm[0], out_bwd, out_fwd};

  // a stop leaves all pins and driven duties at zero
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_action == ACT_STOP |=>
      fwd_pin_state == '0 && bwd_pin_state == '0 && out_pwm[0] == '0 &&
      out_pwm[1] == '0 && out_pwm[2] == '0 && out_pwm[3] == '0)
    else $error("stop did not clear pins and duties");

  // clearing counts reports zero counts
  a_clear_counts: assert property (@(posedge clk) disable iff (rst)
    advance && in_action == ACT_CLEAR |=> out_avg == '0 && out_wheel == '0)
    else $error("count clear not reflected in result");

  // speed sync never touches the front left wheel
  a_sync_keeps_fl: assert property (@(posedge clk) disable iff (rst)
    advance && in_action == ACT_SYNC |=>
      duty_on_pin[0] == $past(duty_on_pin[0]) && duty_setting[0] == $past(duty_setting[0]))
    else $error("sync changed front left duty");

endmodule
